// ----- rtl/pba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the page bitmap allocator.
// Used by the heap, map and top-level modules; depends on nothing.
package pba_pkg;

	// Managed region geometry (page size and map word size are powers of two,
	// and the page count is a multiple of the map word size).
	localparam int PAGE_COUNT    = 8192;
	localparam int PAGE_BYTES    = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

	localparam int PAGE_W   = $clog2(PAGE_COUNT);
	localparam int START_W  = PAGE_W + 1;
	localparam int WORD_W   = $clog2(MAP_WORDS);
	localparam int BIT_W    = $clog2(MAP_WORD_BITS);
	localparam int PB_SHIFT = $clog2(PAGE_BYTES);

	// Field widths.
	localparam int ADDR_W    = 32;
	localparam int FREE_W    = 14;
	localparam int FUP_W     = 14;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;

	// Size of the managed region in bytes, one bit wider than an address.
	localparam logic [ADDR_W:0] MAP_SPAN = (ADDR_W + 1)'(PAGE_COUNT) * (ADDR_W + 1)'(PAGE_BYTES);

	// Register reset values.
	localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'h0000_0000;
	localparam int                FUP_RST        = 1024;
	localparam logic [FUP_W-1:0]  FUP_RST_V      = FUP_W'(FUP_RST);

	// Map state right after reset: init with the reset register values.
	localparam int                 RESET_START_I = (FUP_RST > PAGE_COUNT) ? PAGE_COUNT : FUP_RST;
	localparam logic [START_W-1:0] RESET_START   = START_W'(RESET_START_I);
	localparam logic [FREE_W-1:0]  RESET_FREE    = FREE_W'(PAGE_COUNT - RESET_START_I);

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_HEAP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_OUT_OF_MEM   = 3'd1,
		ST_OUT_OF_RANGE = 3'd2,
		ST_ALREADY_FREE = 3'd3,
		ST_ZERO_SIZE    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAM_BASE   = 2'd0,
		REG_HEAP_START = 2'd1,
		REG_FIRST_PAGE = 2'd2
	} reg_idx_t;

	// Command from the top level to the map engine.
	typedef struct packed {
		logic               init;
		logic               alloc;
		logic               free;
		logic [START_W-1:0] start;
		logic [PAGE_W-1:0]  page;
	} map_req_t;

	// Status from the map engine back to the top level.
	typedef struct packed {
		logic              idle;
		logic              done;
		status_t           status;
		logic [PAGE_W-1:0] page;
	} map_rsp_t;

endpackage

// ----- rtl/pba_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; no package dependency.
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pba_heap.sv -----
`timescale 1ns / 1ps
// Bump allocator for the kernel heap: origin and pointer registers.
// Depends on pba_pkg.
module pba_heap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          init,
	input  logic                          alloc,
	input  logic [pba_pkg::ADDR_W-1:0]    heap_start,
	input  logic [pba_pkg::ADDR_W-1:0]    request_bytes,
	output logic [pba_pkg::ADDR_W-1:0]    alloc_address,
	output pba_pkg::status_t              alloc_status,
	output logic [pba_pkg::ADDR_W-1:0]    bytes_used
);

	logic [pba_pkg::ADDR_W-1:0] origin_q;
	logic [pba_pkg::ADDR_W-1:0] pointer_q;
	logic [pba_pkg::ADDR_W-1:0] rounded_size;
	logic [pba_pkg::ADDR_W-1:0] aligned_start;
	logic                       zero_req;

	// Size rounds up to 8 bytes and may wrap to zero; start rounds up to 16.
	assign rounded_size  = (request_bytes + 32'd7) & ~32'd7;
	assign aligned_start = (heap_start + 32'd15) & ~32'd15;
	assign zero_req      = (request_bytes == '0);

	// Result of a heap request against the current pointer.
	assign alloc_address = zero_req ? '0 : pointer_q;
	assign alloc_status  = zero_req ? pba_pkg::ST_ZERO_SIZE : pba_pkg::ST_OK;
	assign bytes_used    = pointer_q - origin_q;

	// Heap registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q  <= '0;
			pointer_q <= '0;
		end else if (init) begin
			origin_q  <= aligned_start;
			pointer_q <= aligned_start;
		end else if (alloc && !zero_req) begin
			pointer_q <= pointer_q + rounded_size;
		end
	end

endmodule

// ----- rtl/pba_map.sv -----
`timescale 1ns / 1ps
// Used-page bitmap in a synchronous RAM with its init sweep, first-fit scan,
// page release and free-page count. Depends on pba_pkg and pba_ram.
module pba_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pba_pkg::map_req_t            req,
	output pba_pkg::map_rsp_t            rsp,
	output logic [pba_pkg::FREE_W-1:0]   free_count
);

	localparam int WB = pba_pkg::MAP_WORD_BITS;
	localparam int WW = pba_pkg::WORD_W;
	localparam int BW = pba_pkg::BIT_W;
	localparam int SW = pba_pkg::START_W;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_INIT = 4'b0010,
		M_SCAN = 4'b0100,
		M_FCHK = 4'b1000
	} map_state_t;

	map_state_t                 state_q;
	logic [WW:0]                word_q;
	logic [SW-1:0]              start_q;
	logic                       from_op_q;
	logic                       rd_v_s1;
	logic [WW-1:0]              rd_word_s1;
	logic [BW-1:0]              bit_q;
	logic [pba_pkg::FREE_W-1:0] count_q;
	logic                       done_q;
	pba_pkg::status_t           status_q;
	logic [pba_pkg::PAGE_W-1:0] page_q;

	logic          ram_we;
	logic [WW-1:0] ram_waddr;
	logic [WB-1:0] ram_wdata;
	logic          ram_re;
	logic [WW-1:0] ram_raddr;
	logic [WB-1:0] ram_rdata;

	logic [SW-BW-1:0] start_word;
	logic [BW-1:0]    start_bit;
	logic [WB-1:0]    init_value;
	logic             issue;
	logic [WB-1:0]    masked_word;
	logic [WB-1:0]    free_bits;
	logic             found;
	logic [BW-1:0]    hit_idx;
	logic             free_hit;

	function automatic logic [WB-1:0] low_mask(input logic [BW-1:0] n);
		low_mask = ~({WB{1'b1}} << n);
	endfunction

	function automatic logic [WB-1:0] one_hot(input logic [BW-1:0] n);
		one_hot = {{(WB-1){1'b0}}, 1'b1} << n;
	endfunction

	pba_ram #(
		.WIDTH(WB),
		.DEPTH(pba_pkg::MAP_WORDS)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign start_word = start_q[SW-1:BW];
	assign start_bit  = start_q[BW-1:0];

	// Init pattern: words below the start word all used, the start word partly.
	always_comb begin
		if (32'(word_q[WW-1:0]) < 32'(start_word)) begin
			init_value = '1;
		end else if (32'(word_q[WW-1:0]) == 32'(start_word)) begin
			init_value = low_mask(start_bit);
		end else begin
			init_value = '0;
		end
	end

	// Scan check on the word read last cycle; pages below the start count as used.
	always_comb begin
		masked_word = ram_rdata;
		if (32'(rd_word_s1) == 32'(start_word)) begin
			masked_word = ram_rdata | low_mask(start_bit);
		end
		free_bits = ~masked_word;
		found     = rd_v_s1 && (|free_bits);
		hit_idx   = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				hit_idx = BW'(i);
			end
		end
	end

	assign issue    = (state_q == M_SCAN) && (word_q < (WW + 1)'(pba_pkg::MAP_WORDS)) && !found;
	assign free_hit = ram_rdata[bit_q];

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q[WW-1:0];
		ram_wdata = init_value;
		ram_re    = 1'b0;
		ram_raddr = word_q[WW-1:0];
		case (state_q)
			M_IDLE: begin
				if (req.free) begin
					ram_re    = 1'b1;
					ram_raddr = req.page[pba_pkg::PAGE_W-1:BW];
				end
			end
			M_INIT: begin
				ram_we = 1'b1;
			end
			M_SCAN: begin
				ram_re = issue;
				if (found) begin
					ram_we    = 1'b1;
					ram_waddr = rd_word_s1;
					ram_wdata = ram_rdata | one_hot(hit_idx);
				end
			end
			M_FCHK: begin
				ram_we    = free_hit;
				ram_waddr = rd_word_s1;
				ram_wdata = ram_rdata & ~one_hot(bit_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer; reset starts an init sweep with the reset start page.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= M_INIT;
			word_q     <= '0;
			start_q    <= pba_pkg::RESET_START;
			from_op_q  <= 1'b0;
			rd_v_s1    <= 1'b0;
			rd_word_s1 <= '0;
			bit_q      <= '0;
			count_q    <= pba_pkg::RESET_FREE;
			done_q     <= 1'b0;
			status_q   <= pba_pkg::ST_OK;
			page_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.init) begin
						start_q   <= req.start;
						word_q    <= '0;
						from_op_q <= 1'b1;
						count_q   <= pba_pkg::FREE_W'(pba_pkg::PAGE_COUNT - 32'(req.start));
						state_q   <= M_INIT;
					end else if (req.alloc) begin
						if (32'(req.start) >= pba_pkg::PAGE_COUNT) begin
							done_q   <= 1'b1;
							status_q <= pba_pkg::ST_OUT_OF_MEM;
						end else begin
							start_q <= req.start;
							word_q  <= (WW + 1)'(req.start[SW-1:BW]);
							rd_v_s1 <= 1'b0;
							state_q <= M_SCAN;
						end
					end else if (req.free) begin
						rd_word_s1 <= req.page[pba_pkg::PAGE_W-1:BW];
						bit_q      <= req.page[BW-1:0];
						state_q    <= M_FCHK;
					end
				end
				M_INIT: begin
					word_q <= word_q + 1'b1;
					if (word_q[WW-1:0] == WW'(pba_pkg::MAP_WORDS - 1)) begin
						done_q   <= from_op_q;
						status_q <= pba_pkg::ST_OK;
						state_q  <= M_IDLE;
					end
				end
				M_SCAN: begin
					rd_v_s1 <= issue;
					if (issue) begin
						word_q     <= word_q + 1'b1;
						rd_word_s1 <= word_q[WW-1:0];
					end
					if (found) begin
						count_q  <= count_q - 1'b1;
						page_q   <= {rd_word_s1, hit_idx};
						done_q   <= 1'b1;
						status_q <= pba_pkg::ST_OK;
						state_q  <= M_IDLE;
					end else if (rd_v_s1 && rd_word_s1 == WW'(pba_pkg::MAP_WORDS - 1)) begin
						done_q   <= 1'b1;
						status_q <= pba_pkg::ST_OUT_OF_MEM;
						state_q  <= M_IDLE;
					end
				end
				M_FCHK: begin
					if (free_hit) begin
						count_q  <= count_q + 1'b1;
						status_q <= pba_pkg::ST_OK;
					end else begin
						status_q <= pba_pkg::ST_ALREADY_FREE;
					end
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp.idle   = (state_q == M_IDLE);
	assign rsp.done   = done_q;
	assign rsp.status = status_q;
	assign rsp.page   = page_q;
	assign free_count = count_q;

endmodule

// ----- rtl/page_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the page bitmap allocator: configuration registers, request
// dispatch and result register. Depends on pba_pkg, pba_map and pba_heap.
//
// Usage:
// A request (opcode, free_address, request_bytes) is taken when in_valid is
// high and in_stall is low; every request yields exactly one result
// (result_address, status, free_page_count, heap_bytes_used), taken when
// out_valid is high and out_stall is low. Requests are handled one at a time.
// Heap requests and out-of-range page frees skip the map engine: their result
// goes from the pending result register to the output register. A page free
// reads its bitmap word, then checks and clears the bit. A page alloc scans the
// bitmap from the start word; the bitmap RAM is read one word per cycle. An
// alloc with no usable page at all is answered without a scan.
// An init request rewrites all MAP_WORDS (256) bitmap words, one per cycle.
// After reset the same init sweep runs with in_stall high;
// configuration writes are taken at any time but must not overlap a request.
// A waiting result does not block the next request from being taken; a
// finished result waits inside the block while out_stall holds the previous one.
module page_bitmap_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pba_pkg::ADDR_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pba_pkg::OP_W-1:0]         opcode,
	input  logic [pba_pkg::ADDR_W-1:0]       free_address,
	input  logic [pba_pkg::ADDR_W-1:0]       request_bytes,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pba_pkg::ADDR_W-1:0]       result_address,
	output logic [2:0]                       status,
	output logic [pba_pkg::FREE_W-1:0]       free_page_count,
	output logic [pba_pkg::ADDR_W-1:0]       heap_bytes_used
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_MAP  = 3'b010,
		T_DONE = 3'b100
	} top_state_t;

	top_state_t                  state_q;
	pba_pkg::op_t                op_q;
	logic [pba_pkg::ADDR_W-1:0]  ram_base_q;
	logic [pba_pkg::ADDR_W-1:0]  heap_start_q;
	logic [pba_pkg::FUP_W-1:0]   first_page_q;
	logic [pba_pkg::ADDR_W-1:0]  pend_addr_q;
	pba_pkg::status_t            pend_status_q;
	logic                        out_valid_q;
	logic [pba_pkg::ADDR_W-1:0]  result_address_q;
	pba_pkg::status_t            status_q;
	logic [pba_pkg::FREE_W-1:0]  free_page_count_q;
	logic [pba_pkg::ADDR_W-1:0]  heap_bytes_used_q;

	pba_pkg::op_t                op_in;
	logic                        accept;
	logic [pba_pkg::START_W-1:0] usable_start;
	logic [pba_pkg::ADDR_W-1:0]  free_offset;
	logic                        range_err;
	pba_pkg::map_req_t           map_req;
	pba_pkg::map_rsp_t           map_rsp;
	logic [pba_pkg::FREE_W-1:0]  map_free_count;
	logic [pba_pkg::ADDR_W-1:0]  heap_addr;
	pba_pkg::status_t            heap_status;
	logic [pba_pkg::ADDR_W-1:0]  heap_span;
	logic                        out_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q   <= pba_pkg::RAM_BASE_RST;
			heap_start_q <= pba_pkg::HEAP_START_RST;
			first_page_q <= pba_pkg::FUP_RST_V;
		end else if (cfg_write) begin
			case (pba_pkg::reg_idx_t'(cfg_index))
				pba_pkg::REG_RAM_BASE:   ram_base_q   <= cfg_data;
				pba_pkg::REG_HEAP_START: heap_start_q <= cfg_data;
				pba_pkg::REG_FIRST_PAGE: first_page_q <= cfg_data[pba_pkg::FUP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Request acceptance and decode.
	assign in_stall = !((state_q == T_IDLE) && map_rsp.idle);
	assign accept   = in_valid && !in_stall;
	assign op_in    = pba_pkg::op_t'(opcode);

	assign usable_start = (32'(first_page_q) > pba_pkg::PAGE_COUNT)
		? pba_pkg::START_W'(pba_pkg::PAGE_COUNT)
		: pba_pkg::START_W'(first_page_q);

	// Page free range check: below the base or past the end of the region.
	assign free_offset = free_address - ram_base_q;
	assign range_err   = (free_address < ram_base_q)
		|| ({1'b0, free_offset} >= pba_pkg::MAP_SPAN);

	assign map_req.init  = accept && (op_in == pba_pkg::OP_INIT);
	assign map_req.alloc = accept && (op_in == pba_pkg::OP_ALLOC);
	assign map_req.free  = accept && (op_in == pba_pkg::OP_FREE) && !range_err;
	assign map_req.start = usable_start;
	assign map_req.page  = free_offset[pba_pkg::PB_SHIFT +: pba_pkg::PAGE_W];

	pba_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (map_req),
		.rsp       (map_rsp),
		.free_count(map_free_count)
	);

	pba_heap u_heap (
		.clk          (clk),
		.arst_n       (arst_n),
		.init         (accept && (op_in == pba_pkg::OP_INIT)),
		.alloc        (accept && (op_in == pba_pkg::OP_HEAP)),
		.heap_start   (heap_start_q),
		.request_bytes(request_bytes),
		.alloc_address(heap_addr),
		.alloc_status (heap_status),
		.bytes_used   (heap_span)
	);

	assign out_load = (state_q == T_DONE) && (!out_valid_q || !out_stall);

	// Request sequencing and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			op_q          <= pba_pkg::OP_INIT;
			pend_addr_q   <= '0;
			pend_status_q <= pba_pkg::ST_OK;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						op_q <= op_in;
						if (op_in == pba_pkg::OP_HEAP) begin
							pend_addr_q   <= heap_addr;
							pend_status_q <= heap_status;
							state_q       <= T_DONE;
						end else if (op_in == pba_pkg::OP_FREE && range_err) begin
							pend_addr_q   <= '0;
							pend_status_q <= pba_pkg::ST_OUT_OF_RANGE;
							state_q       <= T_DONE;
						end else begin
							state_q <= T_MAP;
						end
					end
				end
				T_MAP: begin
					if (map_rsp.done) begin
						pend_status_q <= map_rsp.status;
						if (op_q == pba_pkg::OP_ALLOC && map_rsp.status == pba_pkg::ST_OK) begin
							pend_addr_q <= ram_base_q
								+ (pba_pkg::ADDR_W'(map_rsp.page) << pba_pkg::PB_SHIFT);
						end else begin
							pend_addr_q <= '0;
						end
						state_q <= T_DONE;
					end
				end
				T_DONE: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_address_q  <= pend_addr_q;
			status_q          <= pend_status_q;
			free_page_count_q <= map_free_count;
			heap_bytes_used_q <= heap_span;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_address  = result_address_q;
	assign status          = status_q;
	assign free_page_count = free_page_count_q;
	assign heap_bytes_used = heap_bytes_used_q;

	// One request at a time: a taken request closes the input next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request taken while another was in progress");

	// A new result only appears from the completion state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == T_DONE))
		else $error("result shown without a finished request");

	// The map engine is only commanded while idle.
	a_map_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(map_req.init || map_req.alloc || map_req.free) |-> map_rsp.idle)
		else $error("map command issued while the engine was busy");

	// The free count never exceeds the number of pages.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(map_free_count) <= pba_pkg::PAGE_COUNT)
		else $error("free page count above page count");

endmodule
